[rtl/b64_pkg.sv]
// Shared types, constants and the sextet-to-character mapping for the base64 encoder.
`timescale 1ns / 1ps

package b64_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;
    localparam logic [7:0] UPPER_BASE = 8'h41;
    localparam logic [7:0] LOWER_BASE = 8'h61;
    localparam logic [7:0] DIGIT_BASE = 8'h30;

    // one classified byte: the characters it produces and where they stop
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            msg_end;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = UPPER_BASE + {2'b00, v};
        end else if (v < 6'd52) begin
            c = LOWER_BASE + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = DIGIT_BASE + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = PLUS_CHAR;
        end else begin
            c = SLASH_CHAR;
        end
        return c;
    endfunction

endpackage

[rtl/b64_front.sv]
// Front end: takes message bytes, tracks group phase and carry, builds character jobs.
`timescale 1ns / 1ps

module b64_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic [7:0]       in_byte,
    input  logic             in_final,
    input  logic             q_full,
    output logic             in_ready,
    output b64_pkg::push_t   push
);

    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;
    logic       take;
    b64_pkg::job_t job;

    assign in_ready = !q_full;
    assign take     = in_valid && !q_full;

    always_comb begin
        job.chars    = {4{b64_pkg::PAD_CHAR}};
        job.last_idx = 2'd0;
        job.msg_end  = in_final;
        phase_next   = phase_reg;
        carry_next   = carry_reg;
        case (phase_reg)
            PH_1: begin
                job.chars[0] = b64_pkg::sextet_char({carry_reg[1:0], in_byte[7:4]});
                if (in_final) begin
                    job.chars[1] = b64_pkg::sextet_char({in_byte[3:0], 2'b00});
                    job.last_idx = 2'd2;
                end else begin
                    carry_next = in_byte[3:0];
                    phase_next = PH_2;
                end
            end
            PH_2: begin
                job.chars[0] = b64_pkg::sextet_char({carry_reg, in_byte[7:6]});
                job.chars[1] = b64_pkg::sextet_char(in_byte[5:0]);
                job.last_idx = 2'd1;
                carry_next   = 4'd0;
                phase_next   = PH_0;
            end
            default: begin
                job.chars[0] = b64_pkg::sextet_char(in_byte[7:2]);
                if (in_final) begin
                    job.chars[1] = b64_pkg::sextet_char({in_byte[1:0], 4'b0000});
                    job.last_idx = 2'd3;
                end else begin
                    carry_next = {2'b00, in_byte[1:0]};
                    phase_next = PH_1;
                end
            end
        endcase
        if (in_final) begin
            phase_next = PH_0;
            carry_next = 4'd0;
        end
    end

    assign push.valid = take;
    assign push.job   = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_0;
            carry_reg <= 4'd0;
        end else if (take) begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

[rtl/b64_queue.sv]
// Short job queue between the front end and the character emitter.
`timescale 1ns / 1ps

module b64_queue #(
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  b64_pkg::push_t   push,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output b64_pkg::job_t    head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64_pkg::job_t  slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push, do_pop;

    assign full       = count_reg == CW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head_valid;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

[rtl/b64_back.sv]
// Back end: walks the head job one character per cycle, while out_ready does not stall it, into the output register.
`timescale 1ns / 1ps

module b64_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  b64_pkg::job_t    head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_char,
    output logic             out_run_end,
    output logic             out_msg_end
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] char_reg;
    logic       run_end_reg, msg_end_reg;
    logic       adv, load, at_last;

    assign adv     = !valid_reg || out_ready;
    assign load    = adv && head_valid;
    assign at_last = idx_reg == head.last_idx;
    assign pop     = load && at_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            if (adv) begin
                valid_reg <= head_valid;
            end
            if (load) begin
                idx_reg <= at_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            char_reg    <= head.chars[idx_reg];
            run_end_reg <= at_last;
            msg_end_reg <= at_last && head.msg_end;
        end
    end

    assign out_valid   = valid_reg;
    assign out_char    = char_reg;
    assign out_run_end = run_end_reg;
    assign out_msg_end = msg_end_reg;

endmodule

[rtl/base64_stream_encoder.sv]
// Top level of the streaming base64 encoder.
//
//   channel | dir | tdata           | tlast       | tuser
//   s_      | in  | [7:0] data_byte | final_byte  | -
//   m_      | out | [7:0] code_char | message_end | [0] run_end
//
// The output gives one character per cycle unless m_tready stalls it; a byte yields
// 1 to 4 characters (1, 1, 2 inside a group, 4, 3 or 2 on a final byte), so about 4/3
// characters per byte over long messages, paced by the single character emitter.
// The front takes one byte per cycle while the DEPTH-entry job queue has room.
// An accepted byte's job is queued, then its first character loads the output register.
// aresetn clears phase, carry, queue pointers and the output valid.
// A stalled m_ side holds its item; the s_ side stalls only when the queue fills.
`timescale 1ns / 1ps

module base64_stream_encoder #(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] code_char
    output logic       m_tuser,   // [0] run_end
    output logic       m_tlast
);

    b64_pkg::push_t push;
    b64_pkg::job_t  head;
    logic           q_full, head_valid, pop;

    b64_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_final (s_tlast),
        .q_full   (q_full),
        .in_ready (s_tready),
        .push     (push)
    );

    b64_queue #(.DEPTH(DEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    b64_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_char    (m_tdata),
        .out_run_end (m_tuser),
        .out_msg_end (m_tlast)
    );

endmodule

[rtl/b64_checker.sv]
// Port-level checks for the base64 encoder, bound to the top level.
`timescale 1ns / 1ps

module b64_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    logic is_pad;
    assign is_pad = m_tdata == b64_pkg::PAD_CHAR;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled output item changed");

    a_msg_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("message end without run end");

    a_charset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >= 8'h41 && m_tdata <= 8'h5A) || (m_tdata >= 8'h61 &&
            m_tdata <= 8'h7A) || (m_tdata >= 8'h30 && m_tdata <= 8'h39) ||
            m_tdata == b64_pkg::PLUS_CHAR || m_tdata == b64_pkg::SLASH_CHAR || is_pad)
        else $error("character outside the alphabet");

    a_pad_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && is_pad && m_tuser |-> m_tlast)
        else $error("pad closing a run that is not the message end");

endmodule

bind base64_stream_encoder b64_checker u_b64_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
